// ===== src/hmmd_pkg.sv =====
// Package for the handheld memory map decoder.
// Holds the map boundaries, target codes, storage sizes and the stage type.
// No dependencies.
`default_nettype none

package hmmd_pkg;

   localparam int WORK_RAM_BYTES_DEF     = 8192;
   localparam int EXTERNAL_RAM_BYTES_DEF = 8192;
   localparam int HIGH_RAM_BYTES_DEF     = 128;

   localparam int ADDR_W  = 16;
   localparam int DATA_W  = 8;
   localparam int TADDR_W = 19;
   localparam int BANK_W  = 5;
   localparam int TGT_W   = 3;

   localparam logic [ADDR_W-1:0] BOOT_END   = 16'h0100;
   localparam logic [ADDR_W-1:0] BANKED_LO  = 16'h4000;
   localparam logic [ADDR_W-1:0] VIDEO_LO   = 16'h8000;
   localparam logic [ADDR_W-1:0] EXT_LO     = 16'hA000;
   localparam logic [ADDR_W-1:0] WORK_LO    = 16'hC000;
   localparam logic [ADDR_W-1:0] OAM_LO     = 16'hFE00;
   localparam logic [ADDR_W-1:0] UNUSED_LO  = 16'hFEA0;
   localparam logic [ADDR_W-1:0] IO_LO      = 16'hFF00;
   localparam logic [ADDR_W-1:0] JOYPAD_REG = 16'hFF00;
   localparam logic [ADDR_W-1:0] IF_REG     = 16'hFF0F;
   localparam logic [ADDR_W-1:0] VREG_LO    = 16'hFF40;
   localparam logic [ADDR_W-1:0] HIGH_LO    = 16'hFF80;
   localparam logic [ADDR_W-1:0] IE_REG     = 16'hFFFF;

   localparam logic [BANK_W-1:0] BANK_RESET = 5'd1;

   localparam logic [TGT_W-1:0] TGT_NONE   = 3'd0;
   localparam logic [TGT_W-1:0] TGT_ROM    = 3'd1;
   localparam logic [TGT_W-1:0] TGT_BOOT   = 3'd2;
   localparam logic [TGT_W-1:0] TGT_VIDEO  = 3'd3;
   localparam logic [TGT_W-1:0] TGT_JOYPAD = 3'd4;

   localparam logic FUNC_READ  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_BOOT_MAP = 2'd0;

   typedef enum logic [1:0] {
      SRC_DIRECT,
      SRC_MAIN,
      SRC_HIGH
   } src_type;

   typedef struct packed {
      src_type              src;
      logic [DATA_W-1:0]    direct_data;
      logic [TGT_W-1:0]     target;
      logic [TADDR_W-1:0]   target_address;
      logic                 forward_write;
      logic [DATA_W-1:0]    forward_data;
   } stage_type;

endpackage

`default_nettype wire

// ===== src/hmmd_if.sv =====
// Valid/ready channel interfaces for bus accesses and their results.
// Depends on hmmd_pkg for field widths.
`default_nettype none

interface hmmd_req_if import hmmd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              func;
   logic [ADDR_W-1:0] address;
   logic [DATA_W-1:0] write_data;

   modport source (output valid, func, address, write_data, input ready);
   modport sink (input valid, func, address, write_data, output ready);
endinterface

interface hmmd_rsp_if import hmmd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [DATA_W-1:0]  read_data;
   logic [TGT_W-1:0]   target;
   logic [TADDR_W-1:0] target_address;
   logic               forward_write;
   logic [DATA_W-1:0]  forward_data;

   modport source (output valid, read_data, target, target_address, forward_write,
                   forward_data, input ready);
   modport sink (input valid, read_data, target, target_address, forward_write,
                 forward_data, output ready);
endinterface

`default_nettype wire

// ===== src/handheld_memory_map_decoder.sv =====
// A request passes through the stage register and then the output register, which offers its result.
// Throughput: one transfer per cycle unless results stall; the RAM read at the request edge feeds
// the output register. The stage and output registers let a new request in while a result waits.
// Reset: synchronous, active high; clears valids, IE and IF to zero, ROM bank to one,
// boot ROM mapping to zero. RAM contents are undefined until written.
`default_nettype none

module handheld_memory_map_decoder import hmmd_pkg::*; #(
   parameter int WORK_RAM_BYTES     = WORK_RAM_BYTES_DEF,
   parameter int EXTERNAL_RAM_BYTES = EXTERNAL_RAM_BYTES_DEF,
   parameter int HIGH_RAM_BYTES     = HIGH_RAM_BYTES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   hmmd_req_if.sink                   req_bus,
   hmmd_rsp_if.source                 rsp_bus,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output      logic [31:0]           csr_prdata,
   output      logic                  csr_pready
);

   localparam int WORK_AW    = $clog2(WORK_RAM_BYTES);
   localparam int EXT_AW     = $clog2(EXTERNAL_RAM_BYTES);
   localparam int HIGH_AW    = $clog2(HIGH_RAM_BYTES);
   localparam int MAIN_DEPTH = WORK_RAM_BYTES + EXTERNAL_RAM_BYTES;
   localparam int MAIN_AW    = $clog2(MAIN_DEPTH);

   logic                boot_map_ff, boot_map_in;
   logic [BANK_W-1:0]   bank_ff, bank_in;
   logic [DATA_W-1:0]   ie_ff, ie_in;
   logic [DATA_W-1:0]   iflag_ff, iflag_in;
   logic                s1_valid_ff, s1_valid_in;
   stage_type           s1_ff, s1_in;
   logic                out_valid_ff, out_valid_in;
   stage_type           out_ff, out_in;
   logic [DATA_W-1:0]   out_data_ff, out_data_in;

   logic                accept;
   logic                out_load;
   logic                csr_write;
   logic                is_write;
   logic [ADDR_W-1:0]   a;
   logic [DATA_W-1:0]   wd;
   logic                main_hit, high_hit;
   logic                set_bank, set_ie, set_if;
   logic [MAIN_AW-1:0]  main_addr;
   logic [HIGH_AW-1:0]  high_addr;
   logic [DATA_W-1:0]   main_rdata, high_rdata;
   stage_type           dec;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && (csr_paddr == CSR_BOOT_MAP);
   assign csr_prdata = (csr_paddr == CSR_BOOT_MAP) ? {31'd0, boot_map_ff} : 32'd0;

   assign out_load    = s1_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || out_load;
   assign accept      = req_bus.valid && req_bus.ready;

   assign is_write = (req_bus.func == FUNC_WRITE);
   assign a        = req_bus.address;
   assign wd       = req_bus.write_data;

   always_comb begin
      dec                = '0;
      dec.src            = SRC_DIRECT;
      dec.target         = TGT_NONE;
      main_hit           = 1'b0;
      high_hit           = 1'b0;
      set_bank           = 1'b0;
      set_ie             = 1'b0;
      set_if             = 1'b0;
      main_addr          = MAIN_AW'(a[EXT_AW-1:0]);
      high_addr          = a[HIGH_AW-1:0];
      if (a < BANKED_LO) begin
         if (is_write) begin
            set_bank = 1'b1;
         end else begin
            dec.target         = (a < BOOT_END && boot_map_ff) ? TGT_BOOT : TGT_ROM;
            dec.target_address = TADDR_W'(a);
         end
      end else if (a < VIDEO_LO) begin
         if (!is_write) begin
            dec.target         = TGT_ROM;
            dec.target_address = {bank_ff, a[13:0]};
         end
      end else if (a < EXT_LO) begin
         dec.target = TGT_VIDEO;
      end else if (a < WORK_LO) begin
         main_hit = 1'b1;
      end else if (a < OAM_LO) begin
         main_hit  = 1'b1;
         main_addr = MAIN_AW'(EXTERNAL_RAM_BYTES) + MAIN_AW'(a[WORK_AW-1:0]);
      end else if (a < IO_LO) begin
         if (a < UNUSED_LO) begin
            dec.target = TGT_VIDEO;
         end
      end else if (a == IE_REG) begin
         if (is_write) begin
            set_ie = 1'b1;
         end else begin
            dec.direct_data = ie_ff;
         end
      end else if (a >= HIGH_LO) begin
         high_hit = 1'b1;
      end else if (a == JOYPAD_REG) begin
         dec.target = TGT_JOYPAD;
      end else if (a == IF_REG) begin
         if (is_write) begin
            set_if = 1'b1;
         end else begin
            dec.direct_data = iflag_ff;
         end
      end else if (a >= VREG_LO) begin
         dec.target = TGT_VIDEO;
      end
      if (dec.target == TGT_VIDEO || dec.target == TGT_JOYPAD) begin
         dec.target_address = TADDR_W'(a);
         dec.forward_write  = is_write;
         dec.forward_data   = is_write ? wd : '0;
      end
      if (main_hit && !is_write) begin
         dec.src = SRC_MAIN;
      end
      if (high_hit && !is_write) begin
         dec.src = SRC_HIGH;
      end
   end

   hmmd_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAIN_DEPTH)
   ) u_main_ram (
      .clock (clock),
      .en    (accept && main_hit),
      .we    (is_write),
      .addr  (main_addr),
      .wdata (wd),
      .rdata (main_rdata)
   );

   hmmd_ram #(
      .WIDTH (DATA_W),
      .DEPTH (HIGH_RAM_BYTES)
   ) u_high_ram (
      .clock (clock),
      .en    (accept && high_hit),
      .we    (is_write),
      .addr  (high_addr),
      .wdata (wd),
      .rdata (high_rdata)
   );

   always_comb begin
      boot_map_in  = csr_write ? csr_pwdata[0] : boot_map_ff;
      bank_in      = (accept && set_bank) ? wd[BANK_W-1:0] : bank_ff;
      ie_in        = (accept && set_ie) ? wd : ie_ff;
      iflag_in     = (accept && set_if) ? wd : iflag_ff;
      s1_in        = accept ? dec : s1_ff;
      s1_valid_in  = accept ? 1'b1 : (out_load ? 1'b0 : s1_valid_ff);
      out_in       = out_load ? s1_ff : out_ff;
      out_valid_in = out_load ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_valid_ff);
      out_data_in  = out_data_ff;
      if (out_load) begin
         case (s1_ff.src)
            SRC_MAIN: out_data_in = main_rdata;
            SRC_HIGH: out_data_in = high_rdata;
            default:  out_data_in = s1_ff.direct_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         boot_map_ff  <= 1'b0;
         bank_ff      <= BANK_RESET;
         ie_ff        <= '0;
         iflag_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         boot_map_ff  <= boot_map_in;
         bank_ff      <= bank_in;
         ie_ff        <= ie_in;
         iflag_ff     <= iflag_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff       <= s1_in;
      out_ff      <= out_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.read_data      = out_data_ff;
   assign rsp_bus.target         = out_ff.target;
   assign rsp_bus.target_address = out_ff.target_address;
   assign rsp_bus.forward_write  = out_ff.forward_write;
   assign rsp_bus.forward_data   = out_ff.forward_data;

endmodule

`default_nettype wire

// ===== src/hmmd_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`default_nettype none

module hmmd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en && we) begin
         mem_ff[addr] <= wdata;
      end
      if (en && !we) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== src/hmmd_checker.sv =====
// Port-level checks for the handheld memory map decoder, bound to the top level.
// Depends on hmmd_pkg and the channel interfaces of the top level.
`default_nettype none

module hmmd_checker import hmmd_pkg::*; (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [DATA_W-1:0]  rsp_read_data,
   input wire logic [TGT_W-1:0]   rsp_target,
   input wire logic [TADDR_W-1:0] rsp_target_address,
   input wire logic               rsp_forward_write,
   input wire logic [DATA_W-1:0]  rsp_forward_data
);

   // A result that is not taken stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before its transfer");

   // A stalled result keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable({rsp_read_data, rsp_target, rsp_target_address,
                                          rsp_forward_write, rsp_forward_data}))
      else $error("stalled result changed");

   // Every request transfer must lead to an offered result.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##2 rsp_valid)
      else $error("no result after a request transfer");

   // A result without a target carries no forwarded access.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_target == TGT_NONE |->
         rsp_target_address == '0 && !rsp_forward_write && rsp_forward_data == '0)
      else $error("forwarded fields set without a target");

endmodule

bind handheld_memory_map_decoder hmmd_checker u_hmmd_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_read_data      (rsp_bus.read_data),
   .rsp_target         (rsp_bus.target),
   .rsp_target_address (rsp_bus.target_address),
   .rsp_forward_write  (rsp_bus.forward_write),
   .rsp_forward_data   (rsp_bus.forward_data)
);

`default_nettype wire
